### hw/rtl/ycpr_pkg.sv
// ============================================================================
// ycpr_pkg
// Shared types, coefficient tables and helper functions for the YCbCr pair
// to RGB converter.
// ============================================================================
`default_nettype none

package ycpr_pkg;

    // Conversion mode codes. The spare code behaves as the full-range mode.
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_STUDIO  = 2'd0;
    localparam t_mode MODE_DECIMAL = 2'd1;
    localparam t_mode MODE_FULL    = 2'd2;

    // Accumulator width: the largest sum is about 35.0e6 in studio mode.
    localparam int ACC_W = 28;
    typedef logic signed [ACC_W-1:0] t_acc;

    // Number of register stages from the input register to the result register.
    localparam int PIPE_DEPTH = 8;

    localparam t_acc CHROMA_MID = 28'sd128;

    // Division by 10000 through a reciprocal, exact for inputs below 2^22.
    localparam int DEC_IN_W   = 22;
    localparam int DEC_PROD_W = 45;
    localparam int DEC_Q_LSB  = 36;
    typedef logic [DEC_PROD_W-1:0] t_prod;
    localparam t_prod DEC_RECIP = 45'd6871948;
    localparam t_acc  DEC_SAT   = 28'sd2560000;

    // Green in decimal mode subtracts weighted, already clamped red and blue.
    localparam t_acc DEC_G_RK = 28'sd5094;
    localparam t_acc DEC_G_BK = 28'sd1942;

    // Per-mode coefficients. The red/blue/green offsets fold the mode's constant
    // terms (luma black level, chroma bias, rounding constant) into one addend.
    typedef struct packed {
        t_acc luma;
        t_acc luma_g;
        t_acc red;
        t_acc blue;
        t_acc green_b;
        t_acc green_r;
        t_acc off_r;
        t_acc off_b;
        t_acc off_g;
    } t_coef;

    // Chroma products shared by both pixels of a pair.
    typedef struct packed {
        t_acc red;
        t_acc blue;
        t_acc green_b;
        t_acc green_r;
    } t_chroma;

    function automatic t_coef coef_for(t_mode mode);
        t_coef k;
        unique case (mode)
            MODE_STUDIO: begin
                k = '{luma: 28'sd76309, luma_g: 28'sd76309,
                      red: 28'sd104597, blue: 28'sd132201,
                      green_b: 28'sd25675, green_r: 28'sd53279,
                      off_r: -28'sd1220944, off_b: -28'sd1220944,
                      off_g: -28'sd1220944};
            end
            MODE_DECIMAL: begin
                k = '{luma: 28'sd11644, luma_g: 28'sd19837,
                      red: 28'sd15938, blue: 28'sd20238,
                      green_b: 28'sd0, green_r: 28'sd0,
                      off_r: -28'sd181236, off_b: -28'sd180836,
                      off_g: -28'sd311710};
            end
            default: begin
                k = '{luma: 28'sd16384, luma_g: 28'sd16384,
                      red: 28'sd22970, blue: 28'sd29032,
                      green_b: 28'sd5638, green_r: 28'sd11700,
                      off_r: 28'sd8192, off_b: 28'sd8192,
                      off_g: 28'sd8192};
            end
        endcase
        return k;
    endfunction

    // Arithmetic shift by 14 or 16, then clamp to 0..255. The rounding
    // constant for the 14-bit case is already in the sum.
    function automatic logic [7:0] clamp_shift(t_acc s, logic full);
        t_acc q;
        q = full ? (s >>> 14) : (s >>> 16);
        if (q < 28'sd0) begin
            return 8'd0;
        end else if (q > 28'sd255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic t_prod recip_mul(t_acc s);
        return t_prod'(s[DEC_IN_W-1:0]) * DEC_RECIP;
    endfunction

    function automatic logic [7:0] dec_quot(logic neg, logic sat, t_prod prod);
        if (neg) begin
            return 8'd0;
        end else if (sat) begin
            return 8'd255;
        end
        return prod[DEC_Q_LSB+7:DEC_Q_LSB];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ycpr_pixel_pipe.sv
// ============================================================================
// ycpr_pixel_pipe
// Pipeline for one pixel of the pair: luma products, sums, scaling, clamp
// and the dependent green channel of the decimal mode.
// ============================================================================
`default_nettype none

module ycpr_pixel_pipe (
    input  wire logic              i_clk,
    input  wire logic [7:0]        i_luma,
    input  wire ycpr_pkg::t_mode   i_mode,
    input  wire ycpr_pkg::t_chroma i_chroma,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue
);

    // i_luma and i_mode come from the input stage; i_chroma is one stage later.
    ycpr_pkg::t_coef w_k1;
    ycpr_pkg::t_coef w_k2;
    logic            w_full3;
    logic            w_dec4;
    logic            w_dec7;

    ycpr_pkg::t_acc  r_s2_pl;
    ycpr_pkg::t_acc  r_s2_plg;
    ycpr_pkg::t_mode r_s2_mode;

    ycpr_pkg::t_acc  r_s3_r;
    ycpr_pkg::t_acc  r_s3_b;
    ycpr_pkg::t_acc  r_s3_g;
    ycpr_pkg::t_mode r_s3_mode;

    logic [7:0]      r_s4_r_sh;
    logic [7:0]      r_s4_b_sh;
    logic [7:0]      r_s4_g_sh;
    logic            r_s4_r_neg;
    logic            r_s4_r_sat;
    logic            r_s4_b_neg;
    logic            r_s4_b_sat;
    ycpr_pkg::t_prod r_s4_r_prod;
    ycpr_pkg::t_prod r_s4_b_prod;
    ycpr_pkg::t_acc  r_s4_g_lin;
    ycpr_pkg::t_mode r_s4_mode;

    logic [7:0]      r_s5_r;
    logic [7:0]      r_s5_b;
    logic [7:0]      r_s5_g_sh;
    ycpr_pkg::t_acc  r_s5_g_lin;
    ycpr_pkg::t_mode r_s5_mode;

    logic [7:0]      r_s6_r;
    logic [7:0]      r_s6_b;
    logic [7:0]      r_s6_g_sh;
    ycpr_pkg::t_acc  r_s6_g_sum;
    ycpr_pkg::t_mode r_s6_mode;

    logic [7:0]      r_s7_r;
    logic [7:0]      r_s7_b;
    logic [7:0]      r_s7_g_sh;
    logic            r_s7_g_neg;
    logic            r_s7_g_sat;
    ycpr_pkg::t_prod r_s7_g_prod;
    ycpr_pkg::t_mode r_s7_mode;

    logic [7:0]      r_s8_r;
    logic [7:0]      r_s8_g;
    logic [7:0]      r_s8_b;

    assign w_k1    = ycpr_pkg::coef_for(i_mode);
    assign w_k2    = ycpr_pkg::coef_for(r_s2_mode);
    assign w_full3 = (r_s3_mode != ycpr_pkg::MODE_STUDIO);
    assign w_dec4  = (r_s4_mode == ycpr_pkg::MODE_DECIMAL);
    assign w_dec7  = (r_s7_mode == ycpr_pkg::MODE_DECIMAL);

    always_ff @(posedge i_clk) begin
        // Luma products.
        r_s2_pl   <= w_k1.luma * ycpr_pkg::t_acc'(i_luma);
        r_s2_plg  <= w_k1.luma_g * ycpr_pkg::t_acc'(i_luma);
        r_s2_mode <= i_mode;

        // Linear sums with folded offsets.
        r_s3_r    <= r_s2_pl + i_chroma.red + w_k2.off_r;
        r_s3_b    <= r_s2_pl + i_chroma.blue + w_k2.off_b;
        r_s3_g    <= r_s2_plg + w_k2.off_g - i_chroma.green_b - i_chroma.green_r;
        r_s3_mode <= r_s2_mode;

        // Shift modes finish here; the decimal mode multiplies by 1/10000.
        r_s4_r_sh   <= ycpr_pkg::clamp_shift(r_s3_r, w_full3);
        r_s4_b_sh   <= ycpr_pkg::clamp_shift(r_s3_b, w_full3);
        r_s4_g_sh   <= ycpr_pkg::clamp_shift(r_s3_g, w_full3);
        r_s4_r_neg  <= r_s3_r[ycpr_pkg::ACC_W-1];
        r_s4_r_sat  <= (r_s3_r >= ycpr_pkg::DEC_SAT);
        r_s4_b_neg  <= r_s3_b[ycpr_pkg::ACC_W-1];
        r_s4_b_sat  <= (r_s3_b >= ycpr_pkg::DEC_SAT);
        r_s4_r_prod <= ycpr_pkg::recip_mul(r_s3_r);
        r_s4_b_prod <= ycpr_pkg::recip_mul(r_s3_b);
        r_s4_g_lin  <= r_s3_g;
        r_s4_mode   <= r_s3_mode;

        r_s5_r     <= w_dec4 ? ycpr_pkg::dec_quot(r_s4_r_neg, r_s4_r_sat, r_s4_r_prod)
                             : r_s4_r_sh;
        r_s5_b     <= w_dec4 ? ycpr_pkg::dec_quot(r_s4_b_neg, r_s4_b_sat, r_s4_b_prod)
                             : r_s4_b_sh;
        r_s5_g_sh  <= r_s4_g_sh;
        r_s5_g_lin <= r_s4_g_lin;
        r_s5_mode  <= r_s4_mode;

        // Decimal green depends on the clamped red and blue.
        r_s6_g_sum <= r_s5_g_lin
                      - ycpr_pkg::DEC_G_RK * ycpr_pkg::t_acc'(r_s5_r)
                      - ycpr_pkg::DEC_G_BK * ycpr_pkg::t_acc'(r_s5_b);
        r_s6_r     <= r_s5_r;
        r_s6_b     <= r_s5_b;
        r_s6_g_sh  <= r_s5_g_sh;
        r_s6_mode  <= r_s5_mode;

        r_s7_g_neg  <= r_s6_g_sum[ycpr_pkg::ACC_W-1];
        r_s7_g_sat  <= (r_s6_g_sum >= ycpr_pkg::DEC_SAT);
        r_s7_g_prod <= ycpr_pkg::recip_mul(r_s6_g_sum);
        r_s7_r      <= r_s6_r;
        r_s7_b      <= r_s6_b;
        r_s7_g_sh   <= r_s6_g_sh;
        r_s7_mode   <= r_s6_mode;

        r_s8_r <= r_s7_r;
        r_s8_b <= r_s7_b;
        r_s8_g <= w_dec7 ? ycpr_pkg::dec_quot(r_s7_g_neg, r_s7_g_sat, r_s7_g_prod)
                         : r_s7_g_sh;
    end

    assign o_red   = r_s8_r;
    assign o_green = r_s8_g;
    assign o_blue  = r_s8_b;

endmodule

`default_nettype wire

### hw/rtl/ycbcr_pair_to_rgb_unit.sv
// ============================================================================
// ycbcr_pair_to_rgb_unit
// Converts two luma samples sharing one Cb/Cr pair into two RGB888 pixels
// using one of three selectable integer formulas.
// ============================================================================
// o_done is the last bit of the valid shift register and rises together with
// the result registers of the two pixel pipes.
// Throughput: one beat per clock; o_busy is always low, and there is no
// output back-pressure, so nothing in the pipeline ever stalls.
// Reset (synchronous, active low) empties the valid pipeline and sets the
// conversion mode back to studio range; data registers are not reset.
`default_nettype none

module ycbcr_pair_to_rgb_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input beat.
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic [7:0] i_luma_first,
    input  wire logic [7:0] i_luma_second,
    input  wire logic [7:0] i_chroma_blue,
    input  wire logic [7:0] i_chroma_red,
    // Mode register write.
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    // Result beat.
    output logic            o_done,
    output logic [7:0]      o_red_first,
    output logic [7:0]      o_green_first,
    output logic [7:0]      o_blue_first,
    output logic [7:0]      o_red_second,
    output logic [7:0]      o_green_second,
    output logic [7:0]      o_blue_second
);

    // The pipeline is eight register stages deep:
    //   1  input capture and mode tag
    //   2  constant multiplies for luma (in each pixel pipe) and for chroma
    //      (shared here, since both pixels use the same Cb and Cr)
    //   3  linear sums with the mode's offsets folded in
    //   4  shift-and-clamp for the studio and full-range modes; reciprocal
    //      multiply for the divide-by-10000 of the decimal mode
    //   5  decimal quotient and clamp for red and blue
    //   6  decimal green, which needs the clamped red and blue
    //   7  reciprocal multiply for decimal green
    //   8  result register
    // Each beat carries its own mode tag down the pipe. The valid bits run
    // in a separate shift register alongside the data.

    logic                      w_accept;
    ycpr_pkg::t_mode           r_mode;
    logic [ycpr_pkg::PIPE_DEPTH-1:0] r_vld;

    logic [7:0]                r_s1_y0;
    logic [7:0]                r_s1_y1;
    logic [7:0]                r_s1_cb;
    logic [7:0]                r_s1_cr;
    ycpr_pkg::t_mode           r_s1_mode;

    ycpr_pkg::t_coef           w_k1;
    ycpr_pkg::t_acc            w_dcb;
    ycpr_pkg::t_acc            w_dcr;
    ycpr_pkg::t_chroma         r_s2_chroma;

    // No back-pressure exists anywhere, so the unit is never busy.
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ycpr_pkg::MODE_STUDIO;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_vld <= {r_vld[ycpr_pkg::PIPE_DEPTH-2:0], w_accept};
        end
    end

    // Stage 1: the input registers load every cycle; r_vld marks real beats.
    always_ff @(posedge i_clk) begin
        r_s1_y0   <= i_luma_first;
        r_s1_y1   <= i_luma_second;
        r_s1_cb   <= i_chroma_blue;
        r_s1_cr   <= i_chroma_red;
        r_s1_mode <= r_mode;
    end

    // Stage 2: chroma products, centered around the 128 offset. In decimal
    // mode the green chroma coefficients are zero.
    assign w_k1  = ycpr_pkg::coef_for(r_s1_mode);
    assign w_dcb = ycpr_pkg::t_acc'(r_s1_cb) - ycpr_pkg::CHROMA_MID;
    assign w_dcr = ycpr_pkg::t_acc'(r_s1_cr) - ycpr_pkg::CHROMA_MID;

    always_ff @(posedge i_clk) begin
        r_s2_chroma.red     <= w_k1.red * w_dcr;
        r_s2_chroma.blue    <= w_k1.blue * w_dcb;
        r_s2_chroma.green_b <= w_k1.green_b * w_dcb;
        r_s2_chroma.green_r <= w_k1.green_r * w_dcr;
    end

    ycpr_pixel_pipe u_pixel_first (
        .i_clk    (i_clk),
        .i_luma   (r_s1_y0),
        .i_mode   (r_s1_mode),
        .i_chroma (r_s2_chroma),
        .o_red    (o_red_first),
        .o_green  (o_green_first),
        .o_blue   (o_blue_first)
    );

    ycpr_pixel_pipe u_pixel_second (
        .i_clk    (i_clk),
        .i_luma   (r_s1_y1),
        .i_mode   (r_s1_mode),
        .i_chroma (r_s2_chroma),
        .o_red    (o_red_second),
        .o_green  (o_green_second),
        .o_blue   (o_blue_second)
    );

    // The strobe marks the single cycle a result beat sits on the outputs.
    assign o_done = r_vld[ycpr_pkg::PIPE_DEPTH-1];

endmodule

`default_nettype wire

### test/tb_ycbcr_pair_to_rgb_unit.sv
// ============================================================================
// tb_ycbcr_pair_to_rgb_unit
// Self-checking bench for the YCbCr pair to RGB888 converter. Every input
// beat that the unit takes is converted by a model inside the bench, and
// each strobed result is compared field by field with the oldest pending
// pixel pair. All four mode codes are exercised with corner values first and
// then with random samples under several sender idle patterns.
// ============================================================================
`timescale 1ns / 1ps

module tb_ycbcr_pair_to_rgb_unit;

    // The pipeline depth doubles as the settle time before a mode change.
    localparam int LATENCY = ycpr_pkg::PIPE_DEPTH;

    // A correct run keeps beats moving on one side or the other, so this limit
    // leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;

    // Random beats per segment: 3 idle patterns x 4 modes x 154 is about 1850.
    localparam int SEGMENT_PAIRS = 154;

    // Corner pairs, packed as {luma_first, luma_second, Cb, Cr}. They hit the
    // sample extremes, the studio black and white levels and neutral chroma,
    // and push every component into both saturation limits.
    localparam logic [31:0] CORNER_PAIRS [6] = '{
        32'h00_00_00_00,
        32'hFF_FF_FF_FF,
        32'h00_FF_80_80,
        32'h10_EB_00_FF,
        32'hEB_10_FF_00,
        32'h80_40_00_00
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_px;

    typedef struct packed {
        t_rgb_px first;
        t_rgb_px second;
    } t_rgb_pair;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the mode register, converts each accepted pair and
    // holds the expected RGB pairs in order until their result beats arrive.
    // ------------------------------------------------------------------------
    class rgb_pair_scoreboard;
        ycpr_pkg::t_mode mode;
        t_rgb_pair       pending_rgb[$];
        int unsigned     mismatches;
        int unsigned     pairs_in;
        int unsigned     pairs_out;
        int unsigned     pairs_per_mode[4];

        function new();
            mode = ycpr_pkg::MODE_STUDIO;
        endfunction

        function void set_mode(ycpr_pkg::t_mode m);
            mode = m;
        endfunction

        function int unsigned pending();
            return pending_rgb.size();
        endfunction

        function logic [7:0] sat8(longint v);
            if (v < 0) begin
                return 8'd0;
            end else if (v > 255) begin
                return 8'd255;
            end
            return v[7:0];
        endfunction

        // Divide by 2^14, rounding half away from zero.
        function longint round_shr14(longint v);
            longint mag;
            longint q;
            mag = (v < 0) ? -v : v;
            q = (mag >>> 14) + ((mag >>> 13) & 1);
            return (v < 0) ? -q : q;
        endfunction

        function t_rgb_px convert_pixel(ycpr_pkg::t_mode m, logic [7:0] y,
                                        logic [7:0] cb, logic [7:0] cr);
            t_rgb_px px;
            longint  ly;
            longint  dcb;
            longint  dcr;
            longint  base;
            ly  = longint'(y);
            dcb = longint'(cb) - 128;
            dcr = longint'(cr) - 128;
            case (m)
                ycpr_pkg::MODE_STUDIO: begin
                    // 16.16 fixed point; the arithmetic shift floors.
                    base = 76309 * (ly - 16);
                    px.red   = sat8((base + 104597 * dcr) >>> 16);
                    px.green = sat8((base - 25675 * dcb - 53279 * dcr) >>> 16);
                    px.blue  = sat8((base + 132201 * dcb) >>> 16);
                end
                ycpr_pkg::MODE_DECIMAL: begin
                    // Division truncates; green uses the saturated red and blue.
                    base = 11644 * ly;
                    px.red  = sat8((15938 * longint'(cr) - 2221300 + base) / 10000);
                    px.blue = sat8((20238 * longint'(cb) - 2771300 + base) / 10000);
                    px.green = sat8((19837 * ly - 311710 - 5094 * longint'(px.red)
                                     - 1942 * longint'(px.blue)) / 10000);
                end
                default: begin
                    // Full range; the spare code lands here as well.
                    base = ly <<< 14;
                    px.red   = sat8(round_shr14(base + 22970 * dcr));
                    px.green = sat8(round_shr14(base - 5638 * dcb - 11700 * dcr));
                    px.blue  = sat8(round_shr14(base + 29032 * dcb));
                end
            endcase
            return px;
        endfunction

        function void note_pair(logic [7:0] y0, logic [7:0] y1, logic [7:0] cb,
                                logic [7:0] cr);
            t_rgb_pair want;
            want.first  = convert_pixel(mode, y0, cb, cr);
            want.second = convert_pixel(mode, y1, cb, cr);
            pending_rgb.push_back(want);
            pairs_in++;
            pairs_per_mode[mode]++;
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH pair %0d %s: expected %0d, got %0d",
                             pairs_out, name, want, got);
                end
            end
        endfunction

        function void check_pair(t_rgb_pair got);
            t_rgb_pair want;
            if (pending_rgb.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH: result beat %h with no pair outstanding", got);
                end
                return;
            end
            want = pending_rgb.pop_front();
            check_field("red_first",    want.first.red,    got.first.red);
            check_field("green_first",  want.first.green,  got.first.green);
            check_field("blue_first",   want.first.blue,   got.first.blue);
            check_field("red_second",   want.second.red,   got.second.red);
            check_field("green_second", want.second.green, got.second.green);
            check_field("blue_second",  want.second.blue,  got.second.blue);
            pairs_out++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Unit under test. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_start        = 1'b0;
    logic [7:0] i_luma_first   = 8'd0;
    logic [7:0] i_luma_second  = 8'd0;
    logic [7:0] i_chroma_blue  = 8'd0;
    logic [7:0] i_chroma_red   = 8'd0;
    logic       i_cfg_we       = 1'b0;
    logic [1:0] i_cfg_wdata    = 2'd0;
    logic       o_busy;
    logic       o_done;
    logic [7:0] o_red_first;
    logic [7:0] o_green_first;
    logic [7:0] o_blue_first;
    logic [7:0] o_red_second;
    logic [7:0] o_green_second;
    logic [7:0] o_blue_second;

    ycbcr_pair_to_rgb_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_luma_first   (i_luma_first),
        .i_luma_second  (i_luma_second),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_red_first    (o_red_first),
        .o_green_first  (o_green_first),
        .o_blue_first   (o_blue_first),
        .o_red_second   (o_red_second),
        .o_green_second (o_green_second),
        .o_blue_second  (o_blue_second)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    rgb_pair_scoreboard sb;
    int unsigned        quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Monitor. It samples at the rising edge, so it sees the values that the
    // unit itself samples there; all drivers use nonblocking assignments, so
    // nothing here depends on the order of processes within the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.set_mode(i_cfg_wdata);
            end
            if (i_start && !o_busy) begin
                sb.note_pair(i_luma_first, i_luma_second, i_chroma_blue, i_chroma_red);
            end
            if (o_done) begin
                sb.check_pair({o_red_first, o_green_first, o_blue_first,
                               o_red_second, o_green_second, o_blue_second});
            end
        end
    end

    // Watchdog: a run that stops moving beats on both sides is a failure.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Each task is entered and left in the time step of a rising
    // edge, and it drives for the next edge.
    // ------------------------------------------------------------------------

    // Offers one pair. Before it, the sender idles cycle by cycle, each cycle
    // with the given percentage. The unit takes the beat at the first edge
    // with o_busy low.
    task automatic send_pair(logic [7:0] y0, logic [7:0] y1, logic [7:0] cb,
                             logic [7:0] cr, int idle_pct);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_luma_first  <= y0;
        i_luma_second <= y1;
        i_chroma_blue <= cb;
        i_chroma_red  <= cr;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Stops sending and waits until every pending pair has come back, then
    // lets the pipeline run empty before anything else happens.
    task automatic drain_results();
        i_start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // The mode register is only written while the pipeline is empty.
    task automatic write_mode(ycpr_pkg::t_mode m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Samples lean toward the values where the formulas turn or saturate.
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(11))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            5: return 8'($urandom_range(0, 20));
            6: return 8'($urandom_range(230, 255));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned directed_pairs;
        int unsigned errors;
        int          idle_pct;

        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner pairs in every mode code. Studio range runs first on the
        // reset value of the register; the other codes are written.
        for (int m = 0; m < 4; m++) begin
            if (m != 0) begin
                write_mode(ycpr_pkg::t_mode'(m));
            end
            foreach (CORNER_PAIRS[k]) begin
                send_pair(CORNER_PAIRS[k][31:24], CORNER_PAIRS[k][23:16],
                          CORNER_PAIRS[k][15:8], CORNER_PAIRS[k][7:0], 0);
            end
            drain_results();
        end
        directed_pairs = sb.pairs_in;

        // Random pairs: three sender idle patterns (light, heavy, none), each
        // walking through all four mode codes in a rotated order so that
        // every code, studio range included, is written more than once.
        // Now and then the sender also stops until the pipeline is empty.
        for (int p = 0; p < 3; p++) begin
            idle_pct = (p == 0) ? 13 : (p == 1) ? 76 : 0;
            for (int s = 0; s < 4; s++) begin
                write_mode(ycpr_pkg::t_mode'((s + p + 1) % 4));
                for (int n = 0; n < SEGMENT_PAIRS; n++) begin
                    if ($urandom_range(63) == 0) begin
                        drain_results();
                    end
                    send_pair(pick_sample(), pick_sample(), pick_sample(),
                              pick_sample(), idle_pct);
                end
                drain_results();
            end
        end

        errors = sb.mismatches + sb.pending();
        $display("Converted %0d pixel pairs (%0d corner pairs) with sender idle",
                 sb.pairs_in, directed_pairs);
        $display("rates of 13%%, 76%% and 0%%; pairs per mode code 0..3: %0d %0d %0d %0d",
                 sb.pairs_per_mode[0], sb.pairs_per_mode[1],
                 sb.pairs_per_mode[2], sb.pairs_per_mode[3]);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### ycbcr_pair_to_rgb_unit.f
hw/rtl/ycpr_pkg.sv
hw/rtl/ycpr_pixel_pipe.sv
hw/rtl/ycbcr_pair_to_rgb_unit.sv
test/tb_ycbcr_pair_to_rgb_unit.sv
